// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of the traffic light controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle as its condition.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication that must hold in the cycle after its condition.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/tlc_pkg.sv
// Package with the types, constants and helper functions of the traffic light controller.
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

   // Width of the wrapping totals of passed cars and ticks.
   localparam int TOTAL_WIDTH = 32;

   // Reset values of the configuration registers.
   localparam logic [6:0] GREEN_TIME_RST     = 7'd5;
   localparam logic [7:0] YELLOW_TIME_RST    = 8'd2;
   localparam logic [7:0] RED_TIME_RST       = 8'd4;
   localparam logic [7:0] BUSY_THRESHOLD_RST = 8'd8;
   localparam logic [6:0] BUSY_EXTENSION_RST = 7'd2;
   localparam logic [7:0] CARS_PER_TICK_RST  = 8'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GREEN_TIME     = 3'd0;
   localparam logic [2:0] CSR_YELLOW_TIME    = 3'd1;
   localparam logic [2:0] CSR_RED_TIME       = 3'd2;
   localparam logic [2:0] CSR_BUSY_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_BUSY_EXTENSION = 3'd4;
   localparam logic [2:0] CSR_CARS_PER_TICK  = 3'd5;

   // Request operations.
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_ARRIVE = 2'd1,
      OP_NIGHT  = 2'd2
   } op_type;

   // Light colours.
   typedef enum logic [1:0] {
      COL_GREEN  = 2'd0,
      COL_YELLOW = 2'd1,
      COL_RED    = 2'd2
   } colour_type;

   // Log symbols.
   typedef enum logic [2:0] {
      SYM_NONE      = 3'd0,
      SYM_GREEN     = 3'd1,
      SYM_YELLOW    = 3'd2,
      SYM_RED       = 3'd3,
      SYM_BLINK_ON  = 3'd4,
      SYM_BLINK_OFF = 3'd5
   } sym_type;

   // One request as held in the input register.
   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] car_count;
   } req_type;

   // Current configuration.
   typedef struct packed {
      logic [6:0] green_time;
      logic [7:0] yellow_time;
      logic [7:0] red_time;
      logic [7:0] busy_threshold;
      logic [6:0] busy_extension;
      logic [7:0] cars_per_tick;
   } cfg_type;

   // One result.
   typedef struct packed {
      colour_type  light_colour;
      logic        night_mode;
      logic        blink_lit;
      logic        busy_flag;
      logic [7:0]  ticks_remaining;
      logic [7:0]  queue_length;
      logic [31:0] passed_total;
      logic [31:0] tick_total;
      sym_type     log_symbol;
   } rsp_type;

   // Colour that follows the given one.
   function automatic colour_type next_colour(input colour_type c);
      colour_type n;
      unique case (c)
         COL_GREEN:  n = COL_YELLOW;
         COL_YELLOW: n = COL_RED;
         default:    n = COL_GREEN;
      endcase
      return n;
   endfunction

   // Countdown loaded when a colour starts; a busy queue lengthens green.
   function automatic logic [7:0] phase_time(input colour_type c, input logic busy,
                                             input cfg_type cfg);
      logic [7:0] t;
      unique case (c)
         COL_GREEN:  t = busy ? ({1'b0, cfg.green_time} + {1'b0, cfg.busy_extension})
                              : {1'b0, cfg.green_time};
         COL_YELLOW: t = cfg.yellow_time;
         default:    t = cfg.red_time;
      endcase
      return t;
   endfunction

   // Log symbol that names a colour.
   function automatic sym_type colour_symbol(input colour_type c);
      sym_type s;
      unique case (c)
         COL_GREEN:  s = SYM_GREEN;
         COL_YELLOW: s = SYM_YELLOW;
         default:    s = SYM_RED;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/tlc_csr.sv
// Configuration registers of the traffic light controller.
`timescale 1ns / 1ps
`default_nettype none

module tlc_csr
   import tlc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_data,
   output cfg_type         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; indexes past the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GREEN_TIME:     cfg_in.green_time     = csr_data[6:0];
            CSR_YELLOW_TIME:    cfg_in.yellow_time    = csr_data;
            CSR_RED_TIME:       cfg_in.red_time       = csr_data;
            CSR_BUSY_THRESHOLD: cfg_in.busy_threshold = csr_data;
            CSR_BUSY_EXTENSION: cfg_in.busy_extension = csr_data[6:0];
            CSR_CARS_PER_TICK:  cfg_in.cars_per_tick  = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_time     <= GREEN_TIME_RST;
         cfg_ff.yellow_time    <= YELLOW_TIME_RST;
         cfg_ff.red_time       <= RED_TIME_RST;
         cfg_ff.busy_threshold <= BUSY_THRESHOLD_RST;
         cfg_ff.busy_extension <= BUSY_EXTENSION_RST;
         cfg_ff.cars_per_tick  <= CARS_PER_TICK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tlc_in_reg.sv
// Input register that holds one request for the controller core.
`timescale 1ns / 1ps
`default_nettype none

module tlc_in_reg
   import tlc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_car_count,
   input  wire logic       fire,
   output logic            item_valid,
   output req_type         item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // The register takes a new request when empty or when its request moves on.
   assign req_ready  = !valid_ff || fire;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !fire);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.operation <= req_operation;
         item_ff.car_count <= req_car_count;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tlc_core.sv
// Controller state and the combinational update that each request applies to it.
`timescale 1ns / 1ps
`default_nettype none

module tlc_core
   import tlc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   colour_type             colour_ff, colour_in;
   logic                   night_ff, night_in;
   logic                   busy_ff, busy_in;
   logic                   blink_ff, blink_in;
   logic [7:0]             countdown_ff, countdown_in;
   logic [7:0]             waiting_ff, waiting_in;
   logic [TOTAL_WIDTH-1:0] passed_ff, passed_in;
   logic [TOTAL_WIDTH-1:0] ticks_ff, ticks_in;
   sym_type                sym;

   logic [8:0] arrive_sum;
   logic [7:0] go_count;
   logic [7:0] waiting_left;
   logic       busy_left;
   logic [7:0] count_dec;

   // Arrivals saturate the queue at its top value.
   assign arrive_sum = {1'b0, waiting_ff} + {1'b0, item.car_count};

   // Cars that leave on a green tick and what stays behind.
   assign go_count     = (waiting_ff >= cfg.cars_per_tick) ? cfg.cars_per_tick : waiting_ff;
   assign waiting_left = (colour_ff == COL_GREEN) ? (waiting_ff - go_count) : waiting_ff;
   assign busy_left    = (colour_ff == COL_GREEN && waiting_left <= cfg.busy_threshold)
                         ? 1'b0 : busy_ff;
   assign count_dec    = (countdown_ff != 8'd0) ? (countdown_ff - 8'd1) : 8'd0;

   // Next state for the request being processed.
   always_comb begin
      colour_in    = colour_ff;
      night_in     = night_ff;
      busy_in      = busy_ff;
      blink_in     = blink_ff;
      countdown_in = countdown_ff;
      waiting_in   = waiting_ff;
      passed_in    = passed_ff;
      ticks_in     = ticks_ff;
      sym          = SYM_NONE;
      unique case (item.operation)
         OP_TICK: begin
            ticks_in = ticks_ff + TOTAL_WIDTH'(1);
            if (night_ff) begin
               blink_in = !blink_ff;
               sym      = blink_ff ? SYM_BLINK_OFF : SYM_BLINK_ON;
            end else begin
               waiting_in = waiting_left;
               busy_in    = busy_left;
               if (colour_ff == COL_GREEN) begin
                  passed_in = passed_ff + TOTAL_WIDTH'(go_count);
               end
               if (count_dec == 8'd0) begin
                  colour_in    = next_colour(colour_ff);
                  countdown_in = phase_time(next_colour(colour_ff), busy_left, cfg);
               end else begin
                  countdown_in = count_dec;
               end
               sym = colour_symbol(colour_in);
            end
         end
         OP_ARRIVE: begin
            if (item.car_count != 8'd0) begin
               waiting_in = arrive_sum[8] ? 8'hFF : arrive_sum[7:0];
               if (waiting_in > cfg.busy_threshold) begin
                  busy_in = 1'b1;
               end
            end
         end
         OP_NIGHT: begin
            night_in = !night_ff;
            if (!night_ff) begin
               blink_in = 1'b0;
            end else begin
               colour_in    = COL_RED;
               countdown_in = cfg.red_time;
            end
         end
         default: begin
            sym = SYM_NONE;
         end
      endcase
   end

   // Result shows the state after the request.
   always_comb begin
      result.light_colour    = colour_in;
      result.night_mode      = night_in;
      result.blink_lit       = blink_in;
      result.busy_flag       = busy_in;
      result.ticks_remaining = countdown_in;
      result.queue_length    = waiting_in;
      result.passed_total    = 32'(passed_in);
      result.tick_total      = 32'(ticks_in);
      result.log_symbol      = sym;
   end

   // State registers, updated once per processed request.
   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff    <= COL_RED;
         night_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         blink_ff     <= 1'b0;
         countdown_ff <= RED_TIME_RST;
         waiting_ff   <= 8'd0;
         passed_ff    <= '0;
         ticks_ff     <= '0;
      end else if (fire) begin
         colour_ff    <= colour_in;
         night_ff     <= night_in;
         busy_ff      <= busy_in;
         blink_ff     <= blink_in;
         countdown_ff <= countdown_in;
         waiting_ff   <= waiting_in;
         passed_ff    <= passed_in;
         ticks_ff     <= ticks_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tlc_out_reg.sv
// Result register that holds one result until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module tlc_out_reg
   import tlc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    item_valid,
   output logic         fire,
   input  wire rsp_type result,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   // A request is processed when the result register is free or being emptied.
   assign fire      = item_valid && (!valid_ff || rsp_ready);
   assign valid_in  = fire || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

endmodule

`default_nettype wire

// File: rtl/traffic_light_controller.sv
// Top level of the traffic light controller.
`timescale 1ns / 1ps
`default_nettype none

// Each request is a tick, an arrival of cars or a night mode toggle, and gives
// exactly one result showing the light state after it plus the symbol a log
// would print. The block takes one request per clock cycle when the result side
// keeps up. A request is captured in the input register; the state update is then
// applied and the result register loaded together, and the result register drives
// the output ports. The rate is set by the state update loop in the core, which
// applies one request per cycle while the result register is free or being
// emptied. Configuration writes are taken in any cycle and apply to requests that
// follow; write them only while no request is in flight.
module traffic_light_controller
   import tlc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_car_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_light_colour,
   output logic             rsp_night_mode,
   output logic             rsp_blink_lit,
   output logic             rsp_busy_flag,
   output logic [7:0]       rsp_ticks_remaining,
   output logic [7:0]       rsp_queue_length,
   output logic [31:0]      rsp_passed_total,
   output logic [31:0]      rsp_tick_total,
   output logic [2:0]       rsp_log_symbol,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   cfg_type cfg;
   req_type item;
   logic    item_valid;
   logic    fire;
   rsp_type result;
   rsp_type rsp;

   // Configuration registers.
   tlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input register.
   tlc_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_car_count (req_car_count),
      .fire          (fire),
      .item_valid    (item_valid),
      .item          (item)
   );

   // State and update logic.
   tlc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   // Result register.
   tlc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .fire       (fire),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // Result fields onto their ports.
   assign rsp_light_colour    = rsp.light_colour;
   assign rsp_night_mode      = rsp.night_mode;
   assign rsp_blink_lit       = rsp.blink_lit;
   assign rsp_busy_flag       = rsp.busy_flag;
   assign rsp_ticks_remaining = rsp.ticks_remaining;
   assign rsp_queue_length    = rsp.queue_length;
   assign rsp_passed_total    = rsp.passed_total;
   assign rsp_tick_total      = rsp.tick_total;
   assign rsp_log_symbol      = rsp.log_symbol;

endmodule

`default_nettype wire

// File: rtl/tlc_checker.sv
// Port-level checker of the traffic light controller and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlc_checker
   import tlc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_light_colour,
   input wire logic        rsp_night_mode,
   input wire logic        rsp_blink_lit,
   input wire logic [7:0]  rsp_queue_length,
   input wire logic [31:0] rsp_tick_total,
   input wire logic [2:0]  rsp_log_symbol
);

   logic rsp_stall;
   logic day_symbol;
   logic blink_symbol;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign day_symbol   = rsp_log_symbol == SYM_GREEN || rsp_log_symbol == SYM_YELLOW
                         || rsp_log_symbol == SYM_RED;
   assign blink_symbol = rsp_log_symbol == SYM_BLINK_ON || rsp_log_symbol == SYM_BLINK_OFF;

   // A stalled result stays on the port unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
                rsp_valid && $stable(rsp_queue_length) && $stable(rsp_tick_total))

   // A day tick logs the colour the light has after it.
   `ASSERT_SAME(a_day_symbol, clock, reset, rsp_valid && day_symbol,
                !rsp_night_mode && ({1'b0, rsp_light_colour} + 3'd1) == rsp_log_symbol)

   // A night tick logs the blink phase it enters.
   `ASSERT_SAME(a_blink_symbol, clock, reset, rsp_valid && blink_symbol,
                rsp_night_mode && (rsp_blink_lit == (rsp_log_symbol == SYM_BLINK_ON)))

   // No result comes out right after reset.
   `ASSERT_SAME(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind traffic_light_controller tlc_checker u_tlc_checker (.*);

`default_nettype wire

// File: dv/traffic_light_controller_tb.sv
// Self-checking testbench of the traffic light controller with its own light state predictor.
`timescale 1ns / 1ps

module traffic_light_controller_tb;
   import tlc_pkg::*;

   // Operation and register index that the block must ignore.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] CSR_NONE  = 3'd7;

   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 128;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   // One row of the directed table; pinned rows carry values read off by hand.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] count;
      logic       pinned;
      colour_type colour;
      logic [7:0] remaining;
      logic [7:0] queue;
      sym_type    symbol;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [7:0]  req_car_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_light_colour;
   logic        rsp_night_mode;
   logic        rsp_blink_lit;
   logic        rsp_busy_flag;
   logic [7:0]  rsp_ticks_remaining;
   logic [7:0]  rsp_queue_length;
   logic [31:0] rsp_passed_total;
   logic [31:0] rsp_tick_total;
   logic [2:0]  rsp_log_symbol;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [7:0]  csr_data;

   // Predicted light state and configuration.
   cfg_type     cfg;
   colour_type  light;
   logic        night_on;
   logic        lamp_lit;
   logic        busy_on;
   logic [7:0]  countdown;
   logic [7:0]  waiting;
   logic [31:0] passed;
   logic [31:0] ticks;

   rsp_type      pending_results[$];
   stim_row_type directed_rows[24];

   // Values typed in for the request being offered.
   logic        cur_pinned = 1'b0;
   colour_type  cur_colour = COL_RED;
   logic [7:0]  cur_remaining = 8'd0;
   logic [7:0]  cur_queue = 8'd0;
   sym_type     cur_symbol = SYM_NONE;

   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int          mismatches = 0;
   int          cycle_count = 0;

   traffic_light_controller dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_car_count       (req_car_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_light_colour    (rsp_light_colour),
      .rsp_night_mode      (rsp_night_mode),
      .rsp_blink_lit       (rsp_blink_lit),
      .rsp_busy_flag       (rsp_busy_flag),
      .rsp_ticks_remaining (rsp_ticks_remaining),
      .rsp_queue_length    (rsp_queue_length),
      .rsp_passed_total    (rsp_passed_total),
      .rsp_tick_total      (rsp_tick_total),
      .rsp_log_symbol      (rsp_log_symbol),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Apply one request to the predicted state and return the result it gives.
   task automatic advance_light(input logic [1:0] op, input logic [7:0] count,
                                output rsp_type r);
      logic [7:0] go;
      logic [8:0] sum;
      sym_type    sym;
      sym = SYM_NONE;
      case (op)
         OP_TICK: begin
            ticks++;
            if (night_on) begin
               lamp_lit = !lamp_lit;
               sym = lamp_lit ? SYM_BLINK_ON : SYM_BLINK_OFF;
            end else begin
               // Cars leave the queue only while the light is green.
               if (light == COL_GREEN) begin
                  go = (waiting >= cfg.cars_per_tick) ? cfg.cars_per_tick : waiting;
                  waiting = waiting - go;
                  passed = passed + 32'(go);
                  if (waiting <= cfg.busy_threshold) busy_on = 1'b0;
               end
               if (countdown != 8'd0) countdown--;
               // An expired countdown moves to the next colour and loads its time.
               if (countdown == 8'd0) begin
                  case (light)
                     COL_GREEN: begin
                        light = COL_YELLOW;
                        countdown = cfg.yellow_time;
                     end
                     COL_YELLOW: begin
                        light = COL_RED;
                        countdown = cfg.red_time;
                     end
                     default: begin
                        light = COL_GREEN;
                        countdown = busy_on ? {1'b0, cfg.green_time} + {1'b0, cfg.busy_extension}
                                            : {1'b0, cfg.green_time};
                     end
                  endcase
               end
               case (light)
                  COL_GREEN:  sym = SYM_GREEN;
                  COL_YELLOW: sym = SYM_YELLOW;
                  default:    sym = SYM_RED;
               endcase
            end
         end
         OP_ARRIVE: begin
            // Arrivals saturate the queue at its top.
            if (count != 8'd0) begin
               sum = {1'b0, waiting} + {1'b0, count};
               waiting = sum[8] ? 8'hFF : sum[7:0];
               if (waiting > cfg.busy_threshold) busy_on = 1'b1;
            end
         end
         OP_NIGHT: begin
            night_on = !night_on;
            if (night_on) begin
               lamp_lit = 1'b0;
            end else begin
               light = COL_RED;
               countdown = cfg.red_time;
            end
         end
         default: ;
      endcase
      r.light_colour    = light;
      r.night_mode      = night_on;
      r.blink_lit       = lamp_lit;
      r.busy_flag       = busy_on;
      r.ticks_remaining = countdown;
      r.queue_length    = waiting;
      r.passed_total    = passed;
      r.tick_total      = ticks;
      r.log_symbol      = sym;
   endtask

   // Scoreboard: check results, track register writes and predict each accepted request.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("Result arrived with no request pending at cycle %0d", cycle_count);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_light_colour !== want.light_colour || rsp_night_mode !== want.night_mode ||
                   rsp_blink_lit !== want.blink_lit || rsp_busy_flag !== want.busy_flag ||
                   rsp_ticks_remaining !== want.ticks_remaining ||
                   rsp_queue_length !== want.queue_length ||
                   rsp_passed_total !== want.passed_total || rsp_tick_total !== want.tick_total ||
                   rsp_log_symbol !== want.log_symbol) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("Mismatch at cycle %0d", cycle_count);
                     $display("  expected c=%0d n=%0b b=%0b y=%0b r=%0d q=%0d p=%0d t=%0d s=%0d",
                              want.light_colour, want.night_mode, want.blink_lit, want.busy_flag,
                              want.ticks_remaining, want.queue_length, want.passed_total,
                              want.tick_total, want.log_symbol);
                     $display("  actual   c=%0d n=%0b b=%0b y=%0b r=%0d q=%0d p=%0d t=%0d s=%0d",
                              rsp_light_colour, rsp_night_mode, rsp_blink_lit, rsp_busy_flag,
                              rsp_ticks_remaining, rsp_queue_length, rsp_passed_total,
                              rsp_tick_total, rsp_log_symbol);
                  end
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GREEN_TIME:     cfg.green_time = csr_data[6:0];
               CSR_YELLOW_TIME:    cfg.yellow_time = csr_data;
               CSR_RED_TIME:       cfg.red_time = csr_data;
               CSR_BUSY_THRESHOLD: cfg.busy_threshold = csr_data;
               CSR_BUSY_EXTENSION: cfg.busy_extension = csr_data[6:0];
               CSR_CARS_PER_TICK:  cfg.cars_per_tick = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_light(req_operation, req_car_count, got);
            // Hand-typed values stand in for the predicted ones on pinned rows.
            if (cur_pinned) begin
               got.light_colour    = cur_colour;
               got.ticks_remaining = cur_remaining;
               got.queue_length    = cur_queue;
               got.log_symbol      = cur_symbol;
            end
            pending_results.push_back(got);
         end
      end
   end

   // Offer one request after a random gap and return at the falling edge after it is taken.
   task automatic offer_request(input logic [1:0] op, input logic [7:0] count);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation = op;
      req_car_count = count;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Write one register; the caller lowers the valid after its last write.
   task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
      csr_index = idx;
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] green, input logic [7:0] yellow,
                                input logic [7:0] red, input logic [7:0] threshold,
                                input logic [7:0] extension, input logic [7:0] cars);
      write_register(CSR_GREEN_TIME, green);
      write_register(CSR_YELLOW_TIME, yellow);
      write_register(CSR_RED_TIME, red);
      write_register(CSR_BUSY_THRESHOLD, threshold);
      write_register(CSR_BUSY_EXTENSION, extension);
      write_register(CSR_CARS_PER_TICK, cars);
      csr_valid = 1'b0;
   endtask

   // Mostly short phase times so the light keeps cycling, now and then any value.
   function automatic logic [7:0] draw_setting();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8));
   endfunction

   // Stop offering and wait until every pending result has come back.
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Result side: random stalls per result, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            stall = rsp_idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
               rsp_ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready = 1'b1;
            do @(posedge clock); while (!rsp_valid && !hold_request);
            @(negedge clock);
         end
      end
   end

   // Request side: reset, directed table, then random phases under several settings.
   initial begin
      logic [1:0] op;
      logic [7:0] cnt;
      int         pick;
      int         choose;

      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_TICK;
      req_car_count = 8'd0;
      csr_valid = 1'b0;
      csr_index = CSR_GREEN_TIME;
      csr_data = 8'd0;

      cfg.green_time = GREEN_TIME_RST;
      cfg.yellow_time = YELLOW_TIME_RST;
      cfg.red_time = RED_TIME_RST;
      cfg.busy_threshold = BUSY_THRESHOLD_RST;
      cfg.busy_extension = BUSY_EXTENSION_RST;
      cfg.cars_per_tick = CARS_PER_TICK_RST;
      light = COL_RED;
      night_on = 1'b0;
      lamp_lit = 1'b0;
      busy_on = 1'b0;
      countdown = RED_TIME_RST;
      waiting = 8'd0;
      passed = 32'd0;
      ticks = 32'd0;

      // Directed table, run with the reset settings.
      directed_rows = '{
         '{OP_TICK,   8'h00, 1'b1, COL_RED,   8'd3, 8'd0,   SYM_RED},
         '{OP_ARRIVE, 8'h00, 1'b1, COL_RED,   8'd3, 8'd0,   SYM_NONE},
         '{OP_ARRIVE, 8'hFF, 1'b1, COL_RED,   8'd3, 8'd255, SYM_NONE},
         '{OP_ARRIVE, 8'hFF, 1'b1, COL_RED,   8'd3, 8'd255, SYM_NONE},
         '{OP_UNUSED, 8'hAA, 1'b1, COL_RED,   8'd3, 8'd255, SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b1, COL_GREEN, 8'd7, 8'd255, SYM_GREEN},
         '{OP_TICK,   8'h00, 1'b1, COL_GREEN, 8'd6, 8'd253, SYM_GREEN},
         '{OP_NIGHT,  8'h00, 1'b1, COL_GREEN, 8'd6, 8'd253, SYM_NONE},
         '{OP_TICK,   8'h00, 1'b1, COL_GREEN, 8'd6, 8'd253, SYM_BLINK_ON},
         '{OP_TICK,   8'h00, 1'b1, COL_GREEN, 8'd6, 8'd253, SYM_BLINK_OFF},
         '{OP_ARRIVE, 8'h01, 1'b1, COL_GREEN, 8'd6, 8'd254, SYM_NONE},
         '{OP_NIGHT,  8'h00, 1'b1, COL_RED,   8'd4, 8'd254, SYM_NONE},
         '{OP_UNUSED, 8'h55, 1'b1, COL_RED,   8'd4, 8'd254, SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE},
         '{OP_TICK,   8'h00, 1'b0, COL_RED,   8'd0, 8'd0,   SYM_NONE}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         cur_pinned = directed_rows[i].pinned;
         cur_colour = directed_rows[i].colour;
         cur_remaining = directed_rows[i].remaining;
         cur_queue = directed_rows[i].queue;
         cur_symbol = directed_rows[i].symbol;
         offer_request(directed_rows[i].op, directed_rows[i].count);
      end
      cur_pinned = 1'b0;

      // Random phases; every phase but the first writes its own setting while the block is idle.
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p)
            0: ;
            1: apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            2: apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            3: begin
               write_register(CSR_NONE, 8'hA5);
               apply_setting(draw_setting(), draw_setting(), draw_setting(),
                             8'($urandom_range(0, 24)), draw_setting(), draw_setting());
            end
            PHASES - 1: apply_setting(8'(GREEN_TIME_RST), YELLOW_TIME_RST, RED_TIME_RST,
                                      BUSY_THRESHOLD_RST, 8'(BUSY_EXTENSION_RST),
                                      CARS_PER_TICK_RST);
            default: apply_setting(draw_setting(), draw_setting(), draw_setting(),
                                   8'($urandom_range(0, 24)), draw_setting(), draw_setting());
         endcase

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Idling is redrawn in stretches, some of them with none at all.
            if (k % 40 == 0) begin
               req_idle_on = $urandom_range(0, 2) != 0;
               rsp_idle_on = $urandom_range(0, 2) != 0;
            end
            // Long result hold-off while requests keep coming back to back.
            if (p == 4 && k == 40) begin
               req_idle_on = 1'b0;
               hold_request = 1'b1;
            end
            // Pause the request side until the block has answered everything.
            if (p == 6 && k == 65) drain_results();

            pick = $urandom_range(0, 99);
            cnt = 8'($urandom_range(0, 255));
            if (pick < 58) begin
               op = OP_TICK;
            end else if (pick < 86) begin
               op = OP_ARRIVE;
               choose = $urandom_range(0, 9);
               if (choose == 0) cnt = 8'd0;
               else if (choose > 1) cnt = 8'($urandom_range(1, 4));
            end else if (pick < 96) begin
               op = OP_NIGHT;
            end else begin
               op = OP_UNUSED;
            end
            offer_request(op, cnt);
         end
      end

      drain_results();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
